// File: sv/scale_space_extremum_detect_defines.svh
// ----------------------------------------------------------------------------
// Scale-space extremum detector assertion macros
// Shorthand for clocked implication checks with reset masking.
// ----------------------------------------------------------------------------
`ifndef SCALE_SPACE_EXTREMUM_DETECT_DEFINES_SVH
`define SCALE_SPACE_EXTREMUM_DETECT_DEFINES_SVH

// same-cycle implication
`define SSE_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define SSE_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: sv/sse_pkg.sv
// ----------------------------------------------------------------------------
// Scale-space extremum detector package
// Beat types, register codes and fixed widths shared by all modules.
// ----------------------------------------------------------------------------
package sse_pkg;

	localparam int SAMPLE_W      = 16;
	localparam int SCALES        = 3;
	localparam int WIN_ROWS      = 3;
	localparam int COL_TAPS      = SCALES * WIN_ROWS;
	localparam int WIN_TAPS      = 2 * COL_TAPS;
	localparam int CENTRE_TAP    = COL_TAPS + WIN_ROWS + 1;
	localparam int NUM_LANES     = WIN_TAPS + COL_TAPS - 1;

	localparam int FRAME_WIDTH_W  = 11;
	localparam int FRAME_HEIGHT_W = 13;
	localparam int THRESHOLD_W    = 15;
	localparam int CFG_DATA_W     = 15;
	localparam int CFG_INDEX_W    = 2;

	typedef logic signed [SAMPLE_W-1:0] sample_t;
	typedef logic [SAMPLE_W-2:0]        mag_t;
	typedef logic [FRAME_WIDTH_W-1:0]   frame_width_t;
	typedef logic [FRAME_HEIGHT_W-1:0]  frame_height_t;
	typedef logic [THRESHOLD_W-1:0]     threshold_t;
	typedef logic [9:0]                 centre_col_t;
	typedef logic [11:0]                centre_row_t;

	localparam frame_width_t  FRAME_WIDTH_RST  = 11'd1024;
	localparam frame_height_t FRAME_HEIGHT_RST = 13'd4096;
	localparam threshold_t    THRESHOLD_RST    = '0;

	localparam sample_t SAMPLE_MIN = {1'b1, {(SAMPLE_W-1){1'b0}}};
	localparam mag_t    MAG_MAX    = '1;

	typedef enum logic [CFG_INDEX_W-1:0] {
		CFG_FRAME_WIDTH         = 2'd0,
		CFG_FRAME_HEIGHT        = 2'd1,
		CFG_PRESCREEN_THRESHOLD = 2'd2
	} cfg_index_e;

	typedef struct packed {
		sample_t sample_lower;
		sample_t sample_middle;
		sample_t sample_upper;
		logic    frame_start;
	} pixel_t;

	typedef struct packed {
		centre_col_t centre_col;
		centre_row_t centre_row;
		logic        no_greater_neighbour;
		logic        no_smaller_neighbour;
		logic        passes_prescreen;
		logic        is_candidate;
	} report_t;

	typedef struct packed {
		sample_t lower;
		sample_t middle;
		sample_t upper;
	} scales_t;

	typedef struct packed {
		scales_t older;
		scales_t newer;
	} row_pair_t;

	typedef struct packed {
		logic gt;
		logic lt;
	} lane_flags_t;

endpackage

// File: sv/scale_space_extremum_detect.sv
// Path: the pixel completing a 3x3x3 window passes stage 1, stage 2 and the
// output register before its report is valid.
// Throughput: one pixel per cycle while pixel_stall is low, set by one row buffer
// read and one write per beat and the 26 compare lanes working in a single pass.
// Reset: position counters, valid flags and configuration registers return to
// defaults at once; the row buffer is not cleared, so no warm-up pass is needed.
// ----------------------------------------------------------------------------
// Scale-space extremum detector
// Raster-order 3x3x3 difference-of-Gaussian extremum test with contrast
// pre-screen, using a two-row buffer, a two-column window and parallel lanes.
// ----------------------------------------------------------------------------
`include "scale_space_extremum_detect_defines.svh"

module scale_space_extremum_detect #(
	parameter int MAX_WIDTH  = 1024,
	parameter int MAX_HEIGHT = 4096
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 cfg_write,
	input  logic [sse_pkg::CFG_INDEX_W-1:0]      cfg_index,
	input  logic [sse_pkg::CFG_DATA_W-1:0]       cfg_data,
	input  logic                                 pixel_valid,
	output logic                                 pixel_stall,
	input  sse_pkg::pixel_t                      pixel,
	output logic                                 report_valid,
	input  logic                                 report_stall,
	output sse_pkg::report_t                     report
);

	localparam int CW  = $clog2(MAX_WIDTH);
	localparam int RW  = $clog2(MAX_HEIGHT);
	localparam int WLW = (CW + 1 > sse_pkg::FRAME_WIDTH_W) ? CW + 1 : sse_pkg::FRAME_WIDTH_W;
	localparam int HLW = (RW + 1 > sse_pkg::FRAME_HEIGHT_W) ? RW + 1 : sse_pkg::FRAME_HEIGHT_W;

	sse_pkg::frame_width_t  frame_width_q;
	sse_pkg::frame_height_t frame_height_q;
	sse_pkg::threshold_t    threshold_q;

	logic [CW-1:0] col_q;
	logic [RW-1:0] row_q;
	logic [CW-1:0] col_cur;
	logic [RW-1:0] row_cur;
	logic [WLW-1:0] fw_ext;
	logic [WLW-1:0] w_lim;
	logic [WLW-1:0] col_inc;
	logic [HLW-1:0] fh_ext;
	logic [HLW-1:0] h_lim;
	logic [HLW-1:0] row_inc;
	logic           rep;

	logic adv;
	logic accept;

	logic                 v_s1;
	logic                 rep_s1;
	logic [CW-1:0]        addr_s1;
	sse_pkg::scales_t     sin_s1;
	sse_pkg::centre_col_t col_s1;
	sse_pkg::centre_row_t row_s1;

	logic                 v_s2;
	logic                 pass_s2;
	sse_pkg::centre_col_t col_s2;
	sse_pkg::centre_row_t row_s2;

	sse_pkg::scales_t     pix_scales;
	sse_pkg::row_pair_t   rd_pair;
	sse_pkg::sample_t     window_q [sse_pkg::WIN_TAPS];
	sse_pkg::sample_t     cur [sse_pkg::COL_TAPS];
	sse_pkg::sample_t     centre;
	sse_pkg::mag_t        mag;
	sse_pkg::lane_flags_t flags [sse_pkg::NUM_LANES];
	sse_pkg::report_t     res;

	logic             report_valid_q;
	sse_pkg::report_t report_q;
	logic             skid_v_q;
	sse_pkg::report_t skid_q;
	logic             pop;

	// configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_width_q  <= sse_pkg::FRAME_WIDTH_RST;
			frame_height_q <= sse_pkg::FRAME_HEIGHT_RST;
			threshold_q    <= sse_pkg::THRESHOLD_RST;
		end else if (cfg_write) begin
			unique case (cfg_index)
				sse_pkg::CFG_FRAME_WIDTH: begin
					frame_width_q <= sse_pkg::frame_width_t'(cfg_data);
				end
				sse_pkg::CFG_FRAME_HEIGHT: begin
					frame_height_q <= sse_pkg::frame_height_t'(cfg_data);
				end
				sse_pkg::CFG_PRESCREEN_THRESHOLD: begin
					threshold_q <= sse_pkg::threshold_t'(cfg_data);
				end
				default: begin
				end
			endcase
		end
	end

	assign adv         = !skid_v_q;
	assign pixel_stall = skid_v_q;
	assign accept      = pixel_valid && adv;

	// position of the incoming beat
	always_comb begin
		col_cur = pixel.frame_start ? '0 : col_q;
		row_cur = pixel.frame_start ? '0 : row_q;
		fw_ext  = WLW'(frame_width_q);
		fh_ext  = HLW'(frame_height_q);
		if (fw_ext < WLW'(3)) begin
			w_lim = WLW'(3);
		end else if (fw_ext > WLW'(MAX_WIDTH)) begin
			w_lim = WLW'(MAX_WIDTH);
		end else begin
			w_lim = fw_ext;
		end
		if (fh_ext < HLW'(3)) begin
			h_lim = HLW'(3);
		end else if (fh_ext > HLW'(MAX_HEIGHT)) begin
			h_lim = HLW'(MAX_HEIGHT);
		end else begin
			h_lim = fh_ext;
		end
		col_inc = WLW'(col_cur) + WLW'(1);
		row_inc = HLW'(row_cur) + HLW'(1);
		rep     = (col_cur >= CW'(2)) && (row_cur >= RW'(2));
		pix_scales.lower  = pixel.sample_lower;
		pix_scales.middle = pixel.sample_middle;
		pix_scales.upper  = pixel.sample_upper;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (accept) begin
			if (col_inc >= w_lim) begin
				col_q <= '0;
				row_q <= (row_inc >= h_lim) ? '0 : RW'(row_inc);
			end else begin
				col_q <= CW'(col_inc);
				row_q <= row_cur;
			end
		end
	end

	// stage 1: row buffer read
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1   <= 1'b0;
			rep_s1 <= 1'b0;
		end else if (adv) begin
			v_s1   <= accept;
			rep_s1 <= accept && rep;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			addr_s1 <= col_cur;
			sin_s1  <= pix_scales;
			col_s1  <= sse_pkg::centre_col_t'(col_cur - CW'(1));
			row_s1  <= sse_pkg::centre_row_t'(row_cur - RW'(1));
		end
	end

	sse_row_buf #(
		.DEPTH (MAX_WIDTH)
	) u_row_buf (
		.clk     (clk),
		.rd_en   (accept),
		.rd_addr (col_cur),
		.wr_en   (adv && v_s1),
		.wr_addr (addr_s1),
		.wr_new  (sin_s1),
		.rd_pair (rd_pair)
	);

	always_comb begin
		cur[0] = rd_pair.older.lower;
		cur[1] = rd_pair.newer.lower;
		cur[2] = sin_s1.lower;
		cur[3] = rd_pair.older.middle;
		cur[4] = rd_pair.newer.middle;
		cur[5] = sin_s1.middle;
		cur[6] = rd_pair.older.upper;
		cur[7] = rd_pair.newer.upper;
		cur[8] = sin_s1.upper;
		centre = window_q[sse_pkg::CENTRE_TAP];
		if (centre[sse_pkg::SAMPLE_W-1]) begin
			mag = (centre == sse_pkg::SAMPLE_MIN) ? sse_pkg::MAG_MAX : sse_pkg::mag_t'(-centre);
		end else begin
			mag = sse_pkg::mag_t'(centre);
		end
	end

	// advance the window by one column
	always_ff @(posedge clk) begin
		if (adv && v_s1) begin
			for (int i = 0; i < sse_pkg::COL_TAPS; i++) begin
				window_q[i]                     <= window_q[i + sse_pkg::COL_TAPS];
				window_q[i + sse_pkg::COL_TAPS] <= cur[i];
			end
		end
	end

	for (genvar j = 0; j < sse_pkg::NUM_LANES; j++) begin : g_lane
		localparam int TAP = (j < sse_pkg::CENTRE_TAP) ? j : j + 1;
		sse_pkg::sample_t nb;
		if (TAP < sse_pkg::WIN_TAPS) begin : g_win
			assign nb = window_q[TAP];
		end else begin : g_cur
			assign nb = cur[TAP - sse_pkg::WIN_TAPS];
		end
		sse_lane u_lane (
			.clk       (clk),
			.en        (adv),
			.neighbour (nb),
			.centre    (centre),
			.flags     (flags[j])
		);
	end

	// stage 2: merge
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (adv) begin
			v_s2 <= v_s1 && rep_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			pass_s2 <= mag >= threshold_q;
			col_s2  <= col_s1;
			row_s2  <= row_s1;
		end
	end

	sse_merge u_merge (
		.flags      (flags),
		.centre_col (col_s2),
		.centre_row (row_s2),
		.pass       (pass_s2),
		.report     (res)
	);

	// output register with skid
	assign pop          = report_valid_q && !report_stall;
	assign report_valid = report_valid_q;
	assign report       = report_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			report_valid_q <= 1'b0;
			skid_v_q       <= 1'b0;
		end else if (skid_v_q) begin
			if (pop) begin
				skid_v_q <= 1'b0;
			end
		end else if (v_s2) begin
			if (report_valid_q && !pop) begin
				skid_v_q <= 1'b1;
			end else begin
				report_valid_q <= 1'b1;
			end
		end else if (pop) begin
			report_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (skid_v_q) begin
			if (pop) begin
				report_q <= skid_q;
			end
		end else if (v_s2) begin
			if (report_valid_q && !pop) begin
				skid_q <= res;
			end else begin
				report_q <= res;
			end
		end
	end

	`SSE_ASSERT_IMP(a_skid_behind_out, skid_v_q, report_valid_q, "skid beat with no output beat")
	`SSE_ASSERT_IMP(a_rep_from_item, rep_s1, v_s1, "report flagged on an empty stage")
	`SSE_ASSERT_NXT(a_skid_hold, skid_v_q && report_stall, skid_v_q && $stable(skid_q), "skid lost")
	`SSE_ASSERT_IMP(a_col_range, accept, col_cur <= CW'(MAX_WIDTH - 1), "column beyond row buffer")

endmodule

// File: sv/sse_row_buf.sv
// ----------------------------------------------------------------------------
// Scale-space extremum detector row buffer
// Two previous rows per column in one memory, rotated on every write, with
// a bypass for a read that meets the write of the previous beat.
// ----------------------------------------------------------------------------
module sse_row_buf #(
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  sse_pkg::scales_t         wr_new,
	output sse_pkg::row_pair_t       rd_pair
);

	sse_pkg::row_pair_t mem [DEPTH];
	sse_pkg::row_pair_t rd_q;
	sse_pkg::row_pair_t fwd_pair_q;
	sse_pkg::row_pair_t wr_pair;
	logic               fwd_q;

	assign rd_pair = fwd_q ? fwd_pair_q : rd_q;

	always_comb begin
		wr_pair.older = rd_pair.newer;
		wr_pair.newer = wr_new;
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_pair;
		end
		if (rd_en) begin
			rd_q       <= mem[rd_addr];
			fwd_q      <= wr_en && (rd_addr == wr_addr);
			fwd_pair_q <= wr_pair;
		end
	end

endmodule

// File: sv/sse_lane.sv
// ----------------------------------------------------------------------------
// Scale-space extremum detector compare lane
// Registers whether one neighbour lies strictly above or below the centre.
// ----------------------------------------------------------------------------
module sse_lane (
	input  logic                 clk,
	input  logic                 en,
	input  sse_pkg::sample_t     neighbour,
	input  sse_pkg::sample_t     centre,
	output sse_pkg::lane_flags_t flags
);

	sse_pkg::lane_flags_t flags_s2;

	assign flags = flags_s2;

	always_ff @(posedge clk) begin
		if (en) begin
			flags_s2.gt <= neighbour > centre;
			flags_s2.lt <= neighbour < centre;
		end
	end

endmodule

// File: sv/sse_merge.sv
// ----------------------------------------------------------------------------
// Scale-space extremum detector merge
// Combines the lane flags into the extremum flags and forms the report.
// ----------------------------------------------------------------------------
module sse_merge (
	input  sse_pkg::lane_flags_t flags [sse_pkg::NUM_LANES],
	input  sse_pkg::centre_col_t centre_col,
	input  sse_pkg::centre_row_t centre_row,
	input  logic                 pass,
	output sse_pkg::report_t     report
);

	logic any_gt;
	logic any_lt;

	always_comb begin
		any_gt = 1'b0;
		any_lt = 1'b0;
		for (int i = 0; i < sse_pkg::NUM_LANES; i++) begin
			any_gt = any_gt | flags[i].gt;
			any_lt = any_lt | flags[i].lt;
		end
		report.centre_col           = centre_col;
		report.centre_row           = centre_row;
		report.no_greater_neighbour = !any_gt;
		report.no_smaller_neighbour = !any_lt;
		report.passes_prescreen     = pass;
		report.is_candidate         = pass && (!any_gt || !any_lt);
	end

endmodule
